// ----- src/uer_pkg.sv -----
// uer_pkg: shared types and constants for the ultrasonic echo ranger
// used by ultrasonic_echo_ranger; no dependencies
package uer_pkg;

  // field and counter widths
  localparam int unsigned ElapsedW = 21;
  localparam int unsigned DistW    = 17;
  localparam int unsigned MaxDistW = 8;
  localparam int unsigned RiseW    = 16;
  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 1;

  // trigger pulse shape in ticks
  localparam logic [ElapsedW-1:0] LowTicks  = ElapsedW'(2);
  localparam logic [ElapsedW-1:0] HighTicks = ElapsedW'(12);

  // echo ticks per meter of range limit (5800 us per meter times 1.3)
  localparam logic [12:0] EchoUsPerM = 13'd7540;

  // width * 256 / 5800 == width * 32 / 725, exact for 21-bit widths as
  // (width * DistRecip) >> DistShift with DistRecip = ceil(2^36 / 725)
  localparam int unsigned  RecipW    = 27;
  localparam int unsigned  DistShift = 31;
  localparam logic [RecipW-1:0] DistRecip = 27'd94785486;

  // register reset values
  localparam logic [MaxDistW-1:0] MaxDistReset   = 8'd4;
  localparam logic [RiseW-1:0]    RiseReset      = 16'd500;
  localparam logic [ElapsedW-1:0] EchoLimitReset = 21'd30160;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMaxDist = 1'b0;
  localparam logic [CfgIdxW-1:0] RegRise    = 1'b1;

  // one result
  typedef struct packed {
    logic              trigger;
    logic              busy_res;
    logic              done_res;
    logic              timed_out;
    logic [DistW-1:0]  distance_q8;
  } res_t;

endpackage

// ----- src/ultrasonic_echo_ranger.sv -----
// ultrasonic_echo_ranger: ultrasonic ranging sequencer, one tick per request
// depends on uer_pkg (types, constants)
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------
//  in      | in        | in_valid_i / in_stall_o | start_req_i, echo_i
//  out     | out       | out_valid_o/out_stall_i | trigger_o, busy_res_o, done_res_o,
//          |           |                         | timed_out_o, distance_q8_o
//  cfg     | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// one request per cycle while in_stall_o is low; its result lands in out_q or skid_q
// the sequencer state and a 21x27 reciprocal multiply sit between the state
// registers and the output register as combinational logic
// a skid register behind the output register keeps intake going while one
// result waits; intake stalls only once both hold a result
// reset: sequencer idle, counter zero, registers at max range 4 m and 500 us
module ultrasonic_echo_ranger (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // input requests
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic                         start_req_i,
  input  logic                         echo_i,
  // results
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         trigger_o,
  output logic                         busy_res_o,
  output logic                         done_res_o,
  output logic                         timed_out_o,
  output logic [uer_pkg::DistW-1:0]    distance_q8_o,
  // configuration writes
  input  logic                         cfg_we_i,
  input  logic [uer_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [uer_pkg::CfgDataW-1:0] cfg_data_i
);

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_LOW  = 3'd1,
    PH_HIGH = 3'd2,
    PH_RISE = 3'd3,
    PH_MEAS = 3'd4
  } phase_e;

  localparam int unsigned ProdW = uer_pkg::ElapsedW + uer_pkg::RecipW;

  // configuration registers; the echo limit is kept premultiplied
  logic [uer_pkg::MaxDistW-1:0] max_dist_q;
  logic [uer_pkg::RiseW-1:0]    rise_q;
  logic [uer_pkg::ElapsedW-1:0] echo_limit_q;

  // sequencer state
  phase_e                       phase_q, phase_d;
  logic [uer_pkg::ElapsedW-1:0] elapsed_q, elapsed_d;

  // output register and skid register
  uer_pkg::res_t out_q, skid_q, res_d;
  logic          out_valid_q, skid_valid_q;

  logic                         in_acc;
  logic                         out_take;
  logic [uer_pkg::ElapsedW-1:0] elapsed_inc;
  logic [ProdW-1:0]             dist_prod;
  logic [uer_pkg::DistW-1:0]    dist_meas;
  logic [uer_pkg::DistW-1:0]    dist_tmo;

  assign in_stall_o = skid_valid_q;
  assign in_acc     = in_valid_i && !skid_valid_q;
  assign out_take   = out_valid_q && !out_stall_i;

  // ---------------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_dist_q   <= uer_pkg::MaxDistReset;
      rise_q       <= uer_pkg::RiseReset;
      echo_limit_q <= uer_pkg::EchoLimitReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        uer_pkg::RegMaxDist: begin
          max_dist_q   <= cfg_data_i[uer_pkg::MaxDistW-1:0];
          echo_limit_q <= uer_pkg::ElapsedW'(cfg_data_i[uer_pkg::MaxDistW-1:0])
                          * uer_pkg::ElapsedW'(uer_pkg::EchoUsPerM);
        end
        uer_pkg::RegRise: begin
          rise_q <= cfg_data_i[uer_pkg::RiseW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // tick logic
  // ---------------------------------------------------------------------------
  assign elapsed_inc = elapsed_q + uer_pkg::ElapsedW'(1);

  // echo width to q9.8 meters, width * 256 / 5800 truncated
  assign dist_prod = ProdW'(elapsed_q) * ProdW'(uer_pkg::DistRecip);
  assign dist_meas = dist_prod[uer_pkg::DistShift +: uer_pkg::DistW];
  assign dist_tmo  = {1'b0, max_dist_q, 8'h00};

  always_comb begin
    phase_d = phase_q;
    elapsed_d = elapsed_q;
    res_d = '0;
    res_d.busy_res = 1'b1;

    case (phase_q)
      PH_LOW: begin
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= uer_pkg::LowTicks) begin
          phase_d   = PH_HIGH;
          elapsed_d = '0;
        end
      end
      PH_HIGH: begin
        res_d.trigger = 1'b1;
        elapsed_d = elapsed_inc;
        if (elapsed_inc >= uer_pkg::HighTicks) begin
          phase_d   = PH_RISE;
          elapsed_d = '0;
        end
      end
      PH_RISE: begin
        if (echo_i) begin
          // the rising tick is the first tick of the width
          phase_d   = PH_MEAS;
          elapsed_d = uer_pkg::ElapsedW'(1);
        end else begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > uer_pkg::ElapsedW'(rise_q)) begin
            res_d.done_res    = 1'b1;
            res_d.timed_out   = 1'b1;
            res_d.distance_q8 = dist_tmo;
          end
        end
      end
      PH_MEAS: begin
        if (!echo_i) begin
          res_d.done_res    = 1'b1;
          res_d.distance_q8 = dist_meas;
        end else begin
          elapsed_d = elapsed_inc;
          if (elapsed_inc > echo_limit_q) begin
            res_d.done_res    = 1'b1;
            res_d.timed_out   = 1'b1;
            res_d.distance_q8 = dist_tmo;
          end
        end
      end
      default: begin
        // idle: start on request
        if (start_req_i) begin
          phase_d   = PH_LOW;
          elapsed_d = uer_pkg::ElapsedW'(1);
        end else begin
          phase_d        = PH_IDLE;
          elapsed_d      = '0;
          res_d.busy_res = 1'b0;
        end
      end
    endcase

    // a result ends the sequence
    if (res_d.done_res) begin
      res_d.busy_res = 1'b0;
      phase_d        = PH_IDLE;
      elapsed_d      = '0;
    end
  end

  // ---------------------------------------------------------------------------
  // state and result registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PH_IDLE;
      elapsed_q    <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        phase_q   <= phase_d;
        elapsed_q <= elapsed_d;
      end
      if (!out_valid_q || out_take) begin
        if (skid_valid_q) begin
          // drain the waiting result first
          out_q        <= skid_q;
          out_valid_q  <= 1'b1;
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= in_acc;
          if (in_acc) begin
            out_q <= res_d;
          end
        end
      end else if (in_acc) begin
        // output held: park the new result
        skid_q       <= res_d;
        skid_valid_q <= 1'b1;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign trigger_o     = out_q.trigger;
  assign busy_res_o    = out_q.busy_res;
  assign done_res_o    = out_q.done_res;
  assign timed_out_o   = out_q.timed_out;
  assign distance_q8_o = out_q.distance_q8;

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid register holds a result while the output register is empty");

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.done_res |-> !out_q.busy_res)
    else $error("result reported while still busy");

  a_tmo_with_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.timed_out || out_q.distance_q8 != '0) |-> out_q.done_res)
    else $error("result fields set without done");

  a_done_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_d.done_res |=> phase_q == PH_IDLE && elapsed_q == '0)
    else $error("sequencer not idle after a result");

  a_trigger_in_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && res_d.trigger |-> phase_q == PH_HIGH && res_d.busy_res)
    else $error("trigger driven outside the high phase");

endmodule

// ----- test/ultrasonic_echo_ranger_tb.sv -----
`timescale 1ns / 100ps
// ultrasonic_echo_ranger_tb: self-checking bench for the ultrasonic echo ranger
// feeds microsecond ticks as requests and checks every result against a tick model
// depends on uer_pkg and ultrasonic_echo_ranger
module ultrasonic_echo_ranger_tb;

  localparam int unsigned TrigLowTicks   = 2;
  localparam int unsigned TrigHighTicks  = 12;
  localparam int unsigned UsPerMeter     = 5800;
  localparam int unsigned EchoUsPerMeter = 7540;
  localparam int unsigned DrainTicks     = 16;
  localparam int unsigned MaxReports     = 10;

  typedef enum logic [2:0] {
    SeqIdle, SeqTrigLow, SeqTrigHigh, SeqWaitRise, SeqMeasure
  } seq_phase_e;

  typedef enum int unsigned { StallNone, StallLight, StallHeavy } stall_mode_e;

  typedef struct packed {
    logic start_req;
    logic echo;
  } tick_t;

  logic                         clk_i       = 1'b0;
  logic                         rst_ni      = 1'b0;
  logic                         in_valid    = 1'b0;
  logic                         in_stall;
  logic                         start_req   = 1'b0;
  logic                         echo        = 1'b0;
  logic                         out_valid;
  logic                         out_stall   = 1'b0;
  logic                         trigger;
  logic                         busy_res;
  logic                         done_res;
  logic                         timed_out;
  logic [uer_pkg::DistW-1:0]    distance_q8;
  logic                         cfg_we      = 1'b0;
  logic [uer_pkg::CfgIdxW-1:0]  cfg_index   = '0;
  logic [uer_pkg::CfgDataW-1:0] cfg_data    = '0;

  ultrasonic_echo_ranger i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .start_req_i   (start_req),
    .echo_i        (echo),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .trigger_o     (trigger),
    .busy_res_o    (busy_res),
    .done_res_o    (done_res),
    .timed_out_o   (timed_out),
    .distance_q8_o (distance_q8),
    .cfg_we_i      (cfg_we),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // ticks waiting to be sent, and results predicted for accepted ticks
  tick_t          pending_ticks[$];
  uer_pkg::res_t  expected_results[$];
  int unsigned    ticks_queued = 0;
  int unsigned    ticks_taken  = 0;
  int unsigned    mismatches   = 0;
  logic           req_taken    = 1'b0;

  // sequencer model state and its copy of the registers
  seq_phase_e                   seq_phase   = SeqIdle;
  logic [uer_pkg::ElapsedW-1:0] seq_elapsed = '0;
  logic [uer_pkg::MaxDistW-1:0] range_m     = uer_pkg::MaxDistReset;
  logic [uer_pkg::RiseW-1:0]    rise_limit  = uer_pkg::RiseReset;

  // advance the sequencer model by one tick and return what the block should report
  function automatic uer_pkg::res_t ranger_tick(input tick_t t);
    uer_pkg::res_t     r;
    logic              finished;
    longint unsigned   width_scaled;
    r            = '0;
    r.busy_res   = 1'b1;
    finished     = 1'b0;
    width_scaled = 0;
    case (seq_phase)
      SeqTrigLow: begin
        seq_elapsed = seq_elapsed + uer_pkg::ElapsedW'(1);
        if (32'(seq_elapsed) >= TrigLowTicks) begin
          seq_phase   = SeqTrigHigh;
          seq_elapsed = '0;
        end
      end
      SeqTrigHigh: begin
        r.trigger   = 1'b1;
        seq_elapsed = seq_elapsed + uer_pkg::ElapsedW'(1);
        if (32'(seq_elapsed) >= TrigHighTicks) begin
          seq_phase   = SeqWaitRise;
          seq_elapsed = '0;
        end
      end
      SeqWaitRise: begin
        // the rising tick already counts as the first tick of the width
        if (t.echo) begin
          seq_phase   = SeqMeasure;
          seq_elapsed = uer_pkg::ElapsedW'(1);
        end else begin
          seq_elapsed = seq_elapsed + uer_pkg::ElapsedW'(1);
          if (seq_elapsed > uer_pkg::ElapsedW'(rise_limit)) begin
            finished      = 1'b1;
            r.timed_out   = 1'b1;
            r.distance_q8 = uer_pkg::DistW'({range_m, 8'h00});
          end
        end
      end
      SeqMeasure: begin
        if (!t.echo) begin
          finished      = 1'b1;
          width_scaled  = (64'(seq_elapsed) * 64'(256)) / 64'(UsPerMeter);
          r.distance_q8 = uer_pkg::DistW'(width_scaled);
        end else begin
          seq_elapsed = seq_elapsed + uer_pkg::ElapsedW'(1);
          if (32'(seq_elapsed) > 32'(range_m) * EchoUsPerMeter) begin
            finished      = 1'b1;
            r.timed_out   = 1'b1;
            r.distance_q8 = uer_pkg::DistW'({range_m, 8'h00});
          end
        end
      end
      default: begin
        if (t.start_req) begin
          seq_phase   = SeqTrigLow;
          seq_elapsed = uer_pkg::ElapsedW'(1);
        end else begin
          seq_phase   = SeqIdle;
          seq_elapsed = '0;
          r.busy_res  = 1'b0;
        end
      end
    endcase
    if (finished) begin
      r.done_res  = 1'b1;
      r.busy_res  = 1'b0;
      seq_phase   = SeqIdle;
      seq_elapsed = '0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(input string what, input uer_pkg::res_t want,
                               input uer_pkg::res_t got);
    mismatches++;
    if (mismatches <= MaxReports) begin
      $display("%0t %s: want trig %0b busy %0b done %0b tmo %0b dist %0d", $time, what,
               want.trigger, want.busy_res, want.done_res, want.timed_out, want.distance_q8);
      $display("%0t %s:  got trig %0b busy %0b done %0b tmo %0b dist %0d", $time, what,
               got.trigger, got.busy_res, got.done_res, got.timed_out, got.distance_q8);
    end
  endtask

  // monitor: checks results and runs the model on every accepted request
  always @(posedge clk_i) begin : scoreboard
    uer_pkg::res_t got;
    uer_pkg::res_t want;
    if (rst_ni) begin
      if (out_valid && !out_stall) begin
        got = '{trigger: trigger, busy_res: busy_res, done_res: done_res,
                timed_out: timed_out, distance_q8: distance_q8};
        if (expected_results.size() == 0) begin
          flag_mismatch("result with no request outstanding", '0, got);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) flag_mismatch("result mismatch", want, got);
        end
      end
      if (in_valid && !in_stall) begin
        expected_results.push_back(ranger_tick(tick_t'{start_req: start_req, echo: echo}));
        ticks_taken++;
      end
    end
    req_taken <= rst_ni && in_valid && !in_stall;
  end

  // driver: bursty request sender and a result-side stall pattern of its own
  stall_mode_e stall_mode = StallNone;
  int unsigned stall_left = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;

  always @(negedge clk_i) begin : tick_driver
    tick_t item;
    if (!rst_ni) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 2));
        stall_left = $urandom_range(16, 256);
      end
      stall_left--;
      case (stall_mode)
        StallNone:  out_stall <= 1'b0;
        StallLight: out_stall <= ($urandom_range(0, 3) == 0);
        default:    out_stall <= ($urandom_range(0, 3) != 0);
      endcase

      // a request stays put until the block takes it
      if (!in_valid || req_taken) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_ticks.size() != 0) begin
          item = pending_ticks.pop_front();
          in_valid  <= 1'b1;
          start_req <= item.start_req;
          echo      <= item.echo;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 48);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic push_tick(input logic s, input logic e);
    pending_ticks.push_back('{start_req: s, echo: e});
    ticks_queued++;
  endtask

  // one ranging: start, trigger ticks, echo low for rise_wait ticks,
  // echo high for high_ticks, then the falling edge
  task automatic push_ranging(input int unsigned rise_wait, input int unsigned high_ticks);
    logic        quiet;
    int unsigned i;
    // once a timeout can drop the sequencer to idle, a start would begin a new run
    quiet = (rise_wait > 32'(rise_limit)) ||
            (high_ticks > 32'(range_m) * EchoUsPerMeter);
    push_tick(1'b1, 1'($urandom_range(0, 1)));
    for (i = 0; i < TrigLowTicks + TrigHighTicks - 1; i++)
      push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    for (i = 0; i < rise_wait; i++) push_tick(!quiet && ($urandom_range(0, 3) == 0), 1'b0);
    for (i = 0; i < high_ticks; i++) push_tick(!quiet && ($urandom_range(0, 3) == 0), 1'b1);
    // a start on the result tick must be ignored
    push_tick(!quiet && ($urandom_range(0, 1) == 1), 1'b0);
  endtask

  // random ticks, then a tail that brings the sequencer back to idle from any phase
  task automatic push_noise();
    int unsigned n;
    int unsigned i;
    n = $urandom_range(4, 30);
    for (i = 0; i < n; i++) push_tick($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)));
    for (i = 0; i < TrigLowTicks + TrigHighTicks; i++) push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
  endtask

  // short rangings; small limits are hit exactly or passed by one tick
  task automatic push_random_ranging();
    int unsigned rise_wait;
    int unsigned high_ticks;
    int unsigned echo_limit;
    int unsigned pick;
    echo_limit = 32'(range_m) * EchoUsPerMeter;
    pick = $urandom_range(0, 3);
    if (pick == 0 && 32'(rise_limit) <= 8) rise_wait = 32'(rise_limit) + $urandom_range(0, 1);
    else rise_wait = $urandom_range(0, (32'(rise_limit) < 8) ? 32'(rise_limit) : 8);
    pick = $urandom_range(0, 3);
    if (pick == 0 && echo_limit <= 16) high_ticks = echo_limit + $urandom_range(0, 1);
    else high_ticks = $urandom_range(1, 16);
    if (high_ticks == 0) high_ticks = 1;
    push_ranging(rise_wait, high_ticks);
  endtask

  // wait until every queued tick is taken and every result is back
  task automatic settle();
    while (ticks_taken != ticks_queued || expected_results.size() != 0) @(negedge clk_i);
    repeat (DrainTicks) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [uer_pkg::CfgIdxW-1:0] idx, input int unsigned value);
    @(negedge clk_i);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = uer_pkg::CfgDataW'(value);
    if (idx == uer_pkg::RegMaxDist) range_m = uer_pkg::MaxDistW'(value);
    else rise_limit = uer_pkg::RiseW'(value);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  task automatic run_random_phase(input int unsigned rangings);
    repeat (rangings) begin
      repeat ($urandom_range(0, 3)) push_tick(1'b0, 1'($urandom_range(0, 1)));
      if ($urandom_range(0, 5) == 0) push_noise();
      push_random_ranging();
    end
    settle();
  endtask

  initial begin
    int unsigned i;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset register values: idle ticks and one short clean measurement
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    push_ranging(2, 2);
    settle();

    // zero registers: a rise timeout on the first low waiting tick,
    // then an echo timeout on the second high tick that reports zero
    write_reg(uer_pkg::RegMaxDist, 0);
    write_reg(uer_pkg::RegRise, 0);
    push_tick(1'b1, 1'b1);
    for (i = 0; i < TrigLowTicks + TrigHighTicks - 1; i++) push_tick(1'b1, i[0]);
    push_tick(1'b1, 1'b0);
    push_tick(1'b1, 1'b0);
    for (i = 0; i < TrigLowTicks + TrigHighTicks - 1; i++) push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b0);
    settle();

    write_reg(uer_pkg::RegMaxDist, 32'(uer_pkg::MaxDistReset));
    write_reg(uer_pkg::RegRise, 32'(uer_pkg::RiseReset));
    run_random_phase(3);

    // top of the range with a short rise window, one rise timeout first
    write_reg(uer_pkg::RegMaxDist, 255);
    write_reg(uer_pkg::RegRise, 3);
    push_ranging(4, 1);
    run_random_phase(3);

    write_reg(uer_pkg::RegMaxDist, 0);
    write_reg(uer_pkg::RegRise, 0);
    run_random_phase(2);

    write_reg(uer_pkg::RegRise, $urandom_range(0, 8));
    write_reg(uer_pkg::RegMaxDist, $urandom_range(1, 255));
    run_random_phase(3);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(50_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
